FILE: rtl/core/sdtq_pkg.sv
// ----------------------------------------------------------------------------
// sdtq_pkg
// Shared sizes, codes and types of the sorted deadline timer queue.
// ----------------------------------------------------------------------------
package sdtq_pkg;

   localparam int TIMERS      = 16;
   localparam int MAX_RESULTS = 16;
   localparam int CNT_W       = $clog2(TIMERS + 1);
   localparam int POP_W       = $clog2(MAX_RESULTS);
   localparam int ID_W        = 8;
   localparam int DL_W        = 32;

   // request kinds
   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_DELETE = 2'd1;
   localparam logic [1:0] ACT_TICK   = 2'd2;

   // result status codes
   localparam logic [2:0] STAT_INSERTED  = 3'd0;
   localparam logic [2:0] STAT_FULL      = 3'd1;
   localparam logic [2:0] STAT_DUPLICATE = 3'd2;
   localparam logic [2:0] STAT_DELETED   = 3'd3;
   localparam logic [2:0] STAT_NOT_FOUND = 3'd4;
   localparam logic [2:0] STAT_EXPIRED   = 3'd5;
   localparam logic [2:0] STAT_NONE      = 3'd6;

   // cell operations
   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_INSERT = 2'd1;
   localparam logic [1:0] CELL_REMOVE = 2'd2;
   localparam logic [1:0] CELL_POP    = 2'd3;

   typedef struct packed {
      logic [ID_W-1:0] id;
      logic [DL_W-1:0] deadline;
   } sdtq_entry_type;

   typedef struct packed {
      logic [1:0]      op;
      logic [ID_W-1:0] id;
      logic [DL_W-1:0] deadline;
   } sdtq_cmd_type;

endpackage

FILE: rtl/core/sdtq_cell.sv
// ----------------------------------------------------------------------------
// sdtq_cell
// One slot of the sorted chain: holds a timer, compares it, shifts left/right.
// ----------------------------------------------------------------------------
module sdtq_cell (
   input  logic                    clock,
   input  sdtq_pkg::sdtq_cmd_type  cmd,
   input  logic                    occupied,
   input  logic                    left_lt,
   input  logic                    left_hit,
   input  sdtq_pkg::sdtq_entry_type left_entry,
   input  sdtq_pkg::sdtq_entry_type right_entry,
   output sdtq_pkg::sdtq_entry_type entry,
   output logic                    lt,
   output logic                    hit,
   output logic                    match
);

   sdtq_pkg::sdtq_entry_type entry_ff;
   sdtq_pkg::sdtq_entry_type entry_in;

   assign match = occupied && (entry_ff.id == cmd.id);
   assign lt    = occupied && (entry_ff.deadline < cmd.deadline);
   // set from the matching slot onward
   assign hit   = match || left_hit;
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         sdtq_pkg::CELL_INSERT: begin
            if (!lt) begin
               if (left_lt) begin
                  entry_in.id       = cmd.id;
                  entry_in.deadline = cmd.deadline;
               end else begin
                  entry_in = left_entry;
               end
            end
         end
         sdtq_pkg::CELL_REMOVE: begin
            if (hit) begin
               entry_in = right_entry;
            end
         end
         sdtq_pkg::CELL_POP: begin
            entry_in = right_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

FILE: rtl/core/sorted_deadline_timer_queue.sv
// ----------------------------------------------------------------------------
// sorted_deadline_timer_queue
// Timer list kept sorted by deadline in a chain of compare-shift slots.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata (low bit up)                 | tuser   | tlast
//  req_    | in        | timer_id, deadline, now            | action  | -
//  rsp_    | out       | out_id, out_deadline               | status  | last
//
//  insert and delete: the transfer is taken in the idle state, then the
//  compare-shift across all slots runs in the execute state; the next
//  request waits for that. tick: up to 16 expired timers, one pop per cycle
//  from the head slot of the chain while the output register is free
//  a result waits in the output register while the next request is taken;
//  the execute step stalls while that register is full and not drained
//  reset is synchronous and clears the fill count, pop count and handshake state only
//
module sorted_deadline_timer_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // timer_id[7:0], deadline[39:8], now[71:40]
   input  logic [1:0]  req_tuser,   // action[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // out_id[7:0], out_deadline[39:8]
   output logic [2:0]  rsp_tuser,   // status[2:0]
   output logic        rsp_tlast
);

   localparam int TIMERS = sdtq_pkg::TIMERS;
   localparam int CNT_W  = sdtq_pkg::CNT_W;
   localparam int POP_W  = sdtq_pkg::POP_W;
   localparam int ID_W   = sdtq_pkg::ID_W;
   localparam int DL_W   = sdtq_pkg::DL_W;

   // controller states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_TICK = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [POP_W-1:0] pop_ff, pop_in;

   // captured request (payload, no reset)
   logic [1:0]      act_ff;
   logic [ID_W-1:0] id_ff;
   logic [DL_W-1:0] dl_ff;
   logic [DL_W-1:0] now_ff;

   // output register
   logic            rsp_valid_ff, rsp_valid_in;
   logic [2:0]      rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0] rsp_id_ff, rsp_id_in;
   logic [DL_W-1:0] rsp_dl_ff, rsp_dl_in;
   logic            rsp_last_ff, rsp_last_in;
   logic            rsp_load;

   logic req_take;
   logic out_free;

   sdtq_pkg::sdtq_cmd_type   cmd;
   sdtq_pkg::sdtq_entry_type ent [TIMERS];
   logic                     lt_v    [TIMERS];
   logic                     hit_v   [TIMERS];
   logic                     match_v [TIMERS];
   logic                     occ_v   [TIMERS];

   logic            any_match;
   logic [DL_W-1:0] del_dl;
   logic            head_exp;
   logic            next_exp;
   logic            tick_last;

   assign req_tready = (state_ff == S_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // ---------------------------------------------------------------------
   // slot chain
   // ---------------------------------------------------------------------
   for (genvar i = 0; i < TIMERS; i++) begin : g_cell
      logic                     l_lt;
      logic                     l_hit;
      sdtq_pkg::sdtq_entry_type l_ent;
      sdtq_pkg::sdtq_entry_type r_ent;

      if (i == 0) begin : g_head
         // nothing sits before the head, so an insert may always land here
         assign l_lt  = 1'b1;
         assign l_hit = 1'b0;
         assign l_ent = '0;
      end else begin : g_body
         assign l_lt  = lt_v[i-1];
         assign l_hit = hit_v[i-1];
         assign l_ent = ent[i-1];
      end

      if (i == TIMERS - 1) begin : g_tail
         assign r_ent = '0;
      end else begin : g_mid
         assign r_ent = ent[i+1];
      end

      // slots below the fill count hold live timers
      assign occ_v[i] = (CNT_W'(i) < count_ff);

      sdtq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occupied    (occ_v[i]),
         .left_lt     (l_lt),
         .left_hit    (l_hit),
         .left_entry  (l_ent),
         .right_entry (r_ent),
         .entry       (ent[i]),
         .lt          (lt_v[i]),
         .hit         (hit_v[i]),
         .match       (match_v[i])
      );
   end

   // id lookup across all slots; ids are unique so at most one matches
   always_comb begin
      any_match = 1'b0;
      del_dl    = '0;
      for (int i = 0; i < TIMERS; i++) begin
         any_match = any_match | match_v[i];
         del_dl    = del_dl | (ent[i].deadline & {DL_W{match_v[i]}});
      end
   end

   assign head_exp = (count_ff != '0) && (ent[0].deadline <= now_ff);
   assign next_exp = (ent[1].deadline <= now_ff);
   // this pop ends the tick on the result cap, an empty list or a live next
   assign tick_last = (pop_ff == POP_W'(sdtq_pkg::MAX_RESULTS - 1)) ||
                      (count_ff == CNT_W'(1)) || !next_exp;

   // ---------------------------------------------------------------------
   // controller
   // ---------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pop_in        = pop_ff;
      cmd.op        = sdtq_pkg::CELL_HOLD;
      cmd.id        = id_ff;
      cmd.deadline  = dl_ff;
      rsp_load      = 1'b0;
      rsp_status_in = sdtq_pkg::STAT_NONE;
      rsp_id_in     = id_ff;
      rsp_dl_in     = '0;
      rsp_last_in   = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               pop_in   = '0;
               state_in = (req_tuser == sdtq_pkg::ACT_TICK) ? S_TICK : S_EXEC;
            end
         end

         S_EXEC: begin
            case (act_ff)
               sdtq_pkg::ACT_INSERT: begin
                  if (out_free) begin
                     rsp_load = 1'b1;
                     state_in = S_IDLE;
                     // duplicate check wins over the full check
                     if (any_match) begin
                        rsp_status_in = sdtq_pkg::STAT_DUPLICATE;
                     end else if (count_ff == CNT_W'(TIMERS)) begin
                        rsp_status_in = sdtq_pkg::STAT_FULL;
                     end else begin
                        rsp_status_in = sdtq_pkg::STAT_INSERTED;
                        rsp_dl_in     = dl_ff;
                        cmd.op        = sdtq_pkg::CELL_INSERT;
                        count_in      = count_ff + CNT_W'(1);
                     end
                  end
               end
               sdtq_pkg::ACT_DELETE: begin
                  if (out_free) begin
                     rsp_load = 1'b1;
                     state_in = S_IDLE;
                     if (any_match) begin
                        rsp_status_in = sdtq_pkg::STAT_DELETED;
                        rsp_dl_in     = del_dl;
                        cmd.op        = sdtq_pkg::CELL_REMOVE;
                        count_in      = count_ff - CNT_W'(1);
                     end else begin
                        rsp_status_in = sdtq_pkg::STAT_NOT_FOUND;
                     end
                  end
               end
               default: begin
                  // unused action code: dropped without a result
                  state_in = S_IDLE;
               end
            endcase
         end

         S_TICK: begin
            if (out_free) begin
               rsp_load = 1'b1;
               if (head_exp) begin
                  rsp_status_in = sdtq_pkg::STAT_EXPIRED;
                  rsp_id_in     = ent[0].id;
                  rsp_dl_in     = ent[0].deadline;
                  rsp_last_in   = tick_last;
                  cmd.op        = sdtq_pkg::CELL_POP;
                  count_in      = count_ff - CNT_W'(1);
                  pop_in        = pop_ff + POP_W'(1);
                  if (tick_last) begin
                     state_in = S_IDLE;
                  end
               end else begin
                  // only reached on the first step of a tick
                  rsp_status_in = sdtq_pkg::STAT_NONE;
                  rsp_id_in     = '0;
                  state_in      = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pop_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pop_ff       <= pop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (req_take) begin
         act_ff <= req_tuser;
         id_ff  <= req_tdata[7:0];
         dl_ff  <= req_tdata[39:8];
         now_ff <= req_tdata[71:40];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_dl_ff     <= rsp_dl_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_dl_ff, rsp_id_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TIMERS))
      else $error("fill count above capacity");

   a_sorted_head: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CNT_W'(2)) |-> (ent[0].deadline <= ent[1].deadline))
      else $error("head slots out of deadline order");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == sdtq_pkg::CELL_INSERT) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not grow the list");

   a_pop_expired: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == sdtq_pkg::CELL_POP) |-> (count_ff != '0 && ent[0].deadline <= now_ff))
      else $error("pop of a timer that has not expired");

   a_none_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == sdtq_pkg::STAT_NONE) |-> rsp_last_ff)
      else $error("nothing-expired result without last mark");

endmodule
